// File: design/sib_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sib_pkg
// Shared types and constants of the snapshot interpolation buffer.
// ----------------------------------------------------------------------------
package sib_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int LIM_W   = 5;
    localparam int FRAC_W  = 16;
    localparam int BLEND_W = 17;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic [63:0] stamp;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] pitch;
        logic [15:0] yaw;
        logic [15:0] roll;
    } snap_t;

    typedef struct packed {
        logic        req_type;
        logic [63:0] stamp;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [15:0] ang_pitch;
        logic [15:0] ang_yaw;
        logic [15:0] ang_roll;
    } req_t;

    typedef struct packed {
        logic                found;
        logic [63:0]         out_stamp;
        logic [31:0]         out_x;
        logic [31:0]         out_y;
        logic [31:0]         out_z;
        logic [15:0]         out_pitch;
        logic [15:0]         out_yaw;
        logic [15:0]         out_roll;
        logic [BLEND_W-1:0]  blend;
        logic                blended;
    } res_t;

    // Per-cell command of the shift row
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_TRIM,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

// File: design/sib_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sib_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface sib_if #(parameter type PAYLOAD_T = logic);
    logic     valid;
    logic     ready;
    PAYLOAD_T data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/snapshot_interpolation_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// snapshot_interpolation_buffer
// Time-sorted pose buffer with insert and sample-by-render-time requests.
// ----------------------------------------------------------------------------
// Usage:
//   req  (sink): one beat per request. req_type 0 inserts a snapshot and gives
//        no result; req_type 1 samples the pose at stamp and gives one beat.
//   res  (source): sampled pose, blend weight and flags.
//   max_entries_we/max_entries_wd: limit register; the user must write it
//        only while idle, the block itself does not enforce this.
// Snapshots sit in a row of DEPTH cells kept sorted by timestamp. An insert
// walks the row one cell a cycle to find its slot, shifts the row and loads
// it, then drops the oldest cells one a cycle down to the limit. A sample
// walks the row, runs a 16-step restoring division of the time fraction (one
// quotient bit a cycle), then blends the six channels in multiply steps. One
// request is in work at a time; req.ready is low while busy. The result sits
// in an output register until taken; a stalled receiver holds the block.
// Reset empties the buffer and sets the limit to 16.
// ----------------------------------------------------------------------------
module snapshot_interpolation_buffer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    sib_if.sink                      req,
    sib_if.source                    res,
    input  wire logic                max_entries_we,
    input  wire logic [4:0]          max_entries_wd
);
    import sib_pkg::*;

    state_t               state_reg, state_next;
    logic [LIM_W-1:0]     max_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    req_t                 rq_reg;
    logic [63:0]          rem_reg, rem_next, den_reg, den_next;
    logic [FRAC_W-1:0]    q_reg, q_next;
    logic [4:0]           step_reg, step_next;
    logic [1:0]           mstep_reg, mstep_next;
    res_t                 out_reg, out_next;
    logic                 out_vld_reg, out_vld_next;
    logic                 load_row;
    logic [CNT_W-1:0]     limit;

    snap_t                cell_data [DEPTH];
    cell_op_t             cell_op   [DEPTH];
    snap_t                new_snap;
    snap_t                cur, prv, a_s, b_s;
    logic [IDX_W-1:0]     ptr_idx, prv_idx;

    assign limit = (max_reg > LIM_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(max_reg);

    assign new_snap = '{stamp: rq_reg.stamp, x: rq_reg.pos_x, y: rq_reg.pos_y,
                        z: rq_reg.pos_z, pitch: rq_reg.ang_pitch,
                        yaw: rq_reg.ang_yaw, roll: rq_reg.ang_roll};
    assign ptr_idx  = ptr_reg[IDX_W-1:0];
    assign prv_idx  = ptr_idx - IDX_W'(1);
    assign cur      = cell_data[ptr_idx];
    assign prv      = cell_data[prv_idx];
    assign a_s      = prv;
    assign b_s      = cur;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_row
            sib_cell u_cell (
                .clk        (clk),
                .op         (cell_op[g]),
                .load_data  (new_snap),
                .below_data (cell_data[(g + DEPTH - 1) % DEPTH]),
                .above_data (cell_data[(g + 1) % DEPTH]),
                .data       (cell_data[g])
            );
        end
    endgenerate

    // Blend datapath: one of x/y/z per multiply step, angles alongside
    logic signed [32:0] dpos;
    logic signed [50:0] ppos;
    logic signed [15:0] dang;
    logic signed [33:0] pang;
    logic [31:0]        pa, pb;
    logic [15:0]        aa, ab;
    logic [16:0]        w17;

    assign w17 = {1'b0, q_reg};

    always_comb
    begin
        unique case (mstep_reg)
            2'd0:    begin pa = a_s.x; pb = b_s.x; aa = a_s.pitch; ab = b_s.pitch; end
            2'd1:    begin pa = a_s.y; pb = b_s.y; aa = a_s.yaw;   ab = b_s.yaw;   end
            default: begin pa = a_s.z; pb = b_s.z; aa = a_s.roll;  ab = b_s.roll;  end
        endcase
        dpos = $signed({pb[31], pb}) - $signed({pa[31], pa});
        ppos = dpos * $signed({1'b0, w17});
        dang = $signed(ab - aa);
        pang = dang * $signed({1'b0, w17});
    end

    logic [63:0] rem_sh;
    logic        rem_c;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ptr_next     = ptr_reg;
        rem_next     = rem_reg;
        den_next     = den_reg;
        q_next       = q_reg;
        step_next    = step_reg;
        mstep_next   = mstep_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg;
        load_row     = 1'b0;
        rem_c        = rem_reg[63];
        rem_sh       = {rem_reg[62:0], 1'b0};
        for (int k = 0; k < DEPTH; k++)
            cell_op[k] = CELL_HOLD;
        req.ready    = (state_reg == ST_IDLE) && !out_vld_reg;
        res.valid    = out_vld_reg;
        res.data     = out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    ptr_next = '0;
                    if (req.data.req_type == REQ_INSERT)
                        state_next = ST_INSERT;
                    else
                        state_next = ST_DIV;
                    step_next = '0;
                    load_row  = 1'b1;
                end
            end
            ST_INSERT:
            begin
                if (limit == '0)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else if (ptr_reg < cnt_reg && cur.stamp < rq_reg.stamp)
                    ptr_next = ptr_reg + CNT_W'(1);
                else if (ptr_reg < cnt_reg && cur.stamp == rq_reg.stamp)
                begin
                    cell_op[ptr_idx] = CELL_LOAD;
                    state_next       = ST_TRIM;
                end
                else if (cnt_reg == CNT_W'(DEPTH))
                begin
                    // Full: drop the oldest cell at once (the new item if it is the oldest)
                    if (ptr_reg != '0)
                    begin
                        for (int k = 0; k < DEPTH; k++)
                            if (CNT_W'(k) < ptr_reg - CNT_W'(1))
                                cell_op[k] = CELL_SHIFT_DOWN;
                        cell_op[ptr_idx - IDX_W'(1)] = CELL_LOAD;
                    end
                    state_next = ST_TRIM;
                end
                else
                begin
                    for (int k = 0; k < DEPTH; k++)
                        if (CNT_W'(k) > ptr_reg && CNT_W'(k) <= cnt_reg)
                            cell_op[k] = CELL_SHIFT_UP;
                    cell_op[ptr_idx] = CELL_LOAD;
                    cnt_next         = cnt_reg + CNT_W'(1);
                    state_next       = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                if (cnt_reg > limit)
                begin
                    for (int k = 0; k < DEPTH - 1; k++)
                        cell_op[k] = CELL_SHIFT_DOWN;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                    state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                // step 0: walk the row to the first cell with stamp >= t
                if (step_reg == '0)
                begin
                    out_next = '0;
                    if (cnt_reg == '0)
                        state_next = ST_OUT;
                    else if (cnt_reg == CNT_W'(1) || rq_reg.stamp <= cell_data[0].stamp)
                    begin
                        out_next.found     = 1'b1;
                        out_next.out_stamp = cell_data[0].stamp;
                        out_next.out_x     = cell_data[0].x;
                        out_next.out_y     = cell_data[0].y;
                        out_next.out_z     = cell_data[0].z;
                        out_next.out_pitch = cell_data[0].pitch;
                        out_next.out_yaw   = cell_data[0].yaw;
                        out_next.out_roll  = cell_data[0].roll;
                        state_next         = ST_OUT;
                    end
                    else if (ptr_reg == '0)
                        ptr_next = CNT_W'(1);
                    else if (ptr_reg < cnt_reg && rq_reg.stamp > cur.stamp)
                        ptr_next = ptr_reg + CNT_W'(1);
                    else if (ptr_reg == cnt_reg
                             || (ptr_reg == cnt_reg - CNT_W'(1) && rq_reg.stamp == cur.stamp)
                             || cur.stamp == prv.stamp)
                    begin
                        if (ptr_reg == cnt_reg)
                            ptr_next = cnt_reg - CNT_W'(1);
                        out_next.found = 1'b1;
                        out_next.blend = BLEND_W'(65536);
                        step_next      = 5'd17;
                        state_next     = ST_MUL;
                    end
                    else
                    begin
                        rem_next  = rq_reg.stamp - prv.stamp;
                        den_next  = cur.stamp - prv.stamp;
                        q_next    = '0;
                        step_next = 5'd1;
                    end
                end
                else if (step_reg <= 5'd16)
                begin
                    if (rem_c || rem_sh >= den_reg)
                    begin
                        rem_next = rem_sh - den_reg;
                        q_next   = {q_reg[FRAC_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        q_next   = {q_reg[FRAC_W-2:0], 1'b0};
                    end
                    step_next = step_reg + 5'd1;
                    if (step_reg == 5'd16)
                    begin
                        step_next  = '0;
                        mstep_next = '0;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                if (step_reg == 5'd17)
                begin
                    // Unblended pick of a stored cell
                    out_next.out_stamp = cur.stamp;
                    out_next.out_x     = cur.x;
                    out_next.out_y     = cur.y;
                    out_next.out_z     = cur.z;
                    out_next.out_pitch = cur.pitch;
                    out_next.out_yaw   = cur.yaw;
                    out_next.out_roll  = cur.roll;
                    state_next         = ST_OUT;
                end
                else
                begin
                    out_next.found     = 1'b1;
                    out_next.blended   = 1'b1;
                    out_next.blend     = w17;
                    out_next.out_stamp = rq_reg.stamp;
                    unique case (mstep_reg)
                        2'd0:
                        begin
                            out_next.out_x     = pa + ppos[47:16];
                            out_next.out_pitch = aa + pang[31:16];
                        end
                        2'd1:
                        begin
                            out_next.out_y   = pa + ppos[47:16];
                            out_next.out_yaw = aa + pang[31:16];
                        end
                        default:
                        begin
                            out_next.out_z    = pa + ppos[47:16];
                            out_next.out_roll = aa + pang[31:16];
                        end
                    endcase
                    mstep_next = mstep_reg + 2'd1;
                    if (mstep_reg == 2'd2)
                        state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_vld_reg)
                begin
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (out_vld_reg && res.ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            max_reg     <= LIM_W'(16);
            cnt_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            out_vld_reg <= out_vld_next;
            if (max_entries_we)
                max_reg <= max_entries_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        q_reg     <= q_next;
        step_reg  <= step_next;
        mstep_reg <= mstep_next;
        out_reg   <= out_next;
        if (load_row)
            rq_reg <= req.data;
    end

endmodule
`default_nettype wire

// File: design/sib_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sib_cell
// One slot of the sorted snapshot row: hold, load, or take a neighbor.
// ----------------------------------------------------------------------------
module sib_cell (
    input  wire logic             clk,
    input  wire sib_pkg::cell_op_t op,
    input  wire sib_pkg::snap_t   load_data,
    input  wire sib_pkg::snap_t   below_data,
    input  wire sib_pkg::snap_t   above_data,
    output sib_pkg::snap_t        data
);
    import sib_pkg::*;

    snap_t data_reg;
    snap_t data_next;

    always_comb
    begin
        unique case (op)
            CELL_LOAD:       data_next = load_data;
            CELL_SHIFT_UP:   data_next = below_data;
            CELL_SHIFT_DOWN: data_next = above_data;
            default:         data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
`default_nettype wire

// File: design/sib_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sib_checker
// Port-level checks of the snapshot interpolation buffer.
// ----------------------------------------------------------------------------
module sib_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         req_valid,
    input wire logic         req_ready,
    input wire logic         res_valid,
    input wire logic         res_ready,
    input wire sib_pkg::res_t res_data
);
    import sib_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result beat dropped while stalled");

    a_blend_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.blended |-> res_data.found && !res_data.blend[16])
        else $error("blended result with bad weight");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.found |-> res_data.blend == '0 && !res_data.blended)
        else $error("empty result carries data");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");
endmodule

bind snapshot_interpolation_buffer sib_checker u_sib_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.data)
);
`default_nettype wire

// File: sim/sib_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sib_tb_pkg
// Pose prediction for the snapshot interpolation buffer testbench: a sorted
// snapshot store with trimming, and the sample blend in fixed point.
// ----------------------------------------------------------------------------
package sib_tb_pkg;
    import sib_pkg::*;

    snap_t       pose_store [DEPTH];
    int unsigned pose_count;
    int unsigned pose_limit;

    function automatic void pose_reset();
        pose_count = 0;
        pose_limit = 16;
    endfunction

    function automatic void pose_set_limit(logic [4:0] v);
        pose_limit = v;
    endfunction

    function automatic longint floor_q16(longint p);
        return p >>> 16;
    endfunction

    function automatic logic [31:0] mix_pos(logic [31:0] a, logic [31:0] b,
                                            logic [16:0] w);
        longint fa, d;
        fa = longint'($signed(a));
        d  = longint'($signed(b)) - fa;
        return 32'(fa + floor_q16(d * longint'(w)));
    endfunction

    function automatic logic [15:0] mix_ang(logic [15:0] a, logic [15:0] b,
                                            logic [16:0] w);
        logic [15:0] dd;
        longint d;
        dd = b - a;
        d  = longint'($signed(dd));
        return 16'(longint'($signed(a)) + floor_q16(d * longint'(w)));
    endfunction

    function automatic logic [16:0] time_fraction(logic [63:0] num, logic [63:0] den);
        logic [63:0] rem;
        logic [16:0] q;
        logic        carry;
        rem = num;
        q   = '0;
        for (int k = 0; k < 16; k++)
        begin
            carry = rem[63];
            rem   = rem << 1;
            q     = q << 1;
            if (carry || rem >= den)
            begin
                rem  = rem - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic void pose_insert(req_t r);
        snap_t       s;
        snap_t       merged [DEPTH+1];
        int unsigned lim, p, total, drop;
        lim = (pose_limit > DEPTH) ? DEPTH : pose_limit;
        if (lim == 0)
        begin
            pose_count = 0;
            return;
        end
        s = '{r.stamp, r.pos_x, r.pos_y, r.pos_z, r.ang_pitch, r.ang_yaw, r.ang_roll};
        p = 0;
        while (p < pose_count && pose_store[p].stamp < r.stamp) p++;
        if (p < pose_count && pose_store[p].stamp == r.stamp)
        begin
            pose_store[p] = s;
            total = pose_count;
            for (int i = 0; i < total; i++) merged[i] = pose_store[i];
        end
        else
        begin
            for (int i = 0; i < p; i++) merged[i] = pose_store[i];
            merged[p] = s;
            for (int i = p; i < pose_count; i++) merged[i+1] = pose_store[i];
            total = pose_count + 1;
        end
        drop = (total > lim) ? total - lim : 0;
        for (int i = 0; i < total - drop; i++) pose_store[i] = merged[i+drop];
        pose_count = total - drop;
    endfunction

    function automatic res_t snap_result(snap_t s, logic [16:0] w);
        return '{1'b1, s.stamp, s.x, s.y, s.z, s.pitch, s.yaw, s.roll, w, 1'b0};
    endfunction

    function automatic res_t pose_sample(logic [63:0] t);
        snap_t       a, b;
        logic [16:0] w;
        int unsigned n;
        n = pose_count;
        if (n == 0) return '0;
        if (n == 1 || t <= pose_store[0].stamp) return snap_result(pose_store[0], 17'd0);
        if (t >= pose_store[n-1].stamp) return snap_result(pose_store[n-1], 17'd65536);
        for (int i = 1; i < n; i++)
        begin
            a = pose_store[i-1];
            b = pose_store[i];
            if (t > b.stamp) continue;
            if (b.stamp == a.stamp) return snap_result(b, 17'd65536);
            w = time_fraction(t - a.stamp, b.stamp - a.stamp);
            return '{1'b1, t, mix_pos(a.x, b.x, w), mix_pos(a.y, b.y, w),
                     mix_pos(a.z, b.z, w), mix_ang(a.pitch, b.pitch, w),
                     mix_ang(a.yaw, b.yaw, w), mix_ang(a.roll, b.roll, w), w, 1'b1};
        end
        return snap_result(pose_store[n-1], 17'd65536);
    endfunction
endpackage

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert and sample requests into the snapshot interpolation buffer
// under several idle and stall mixes and limit settings, and checks every
// sampled pose against a fixed-point prediction of the sorted store.
// ----------------------------------------------------------------------------
module testbench;
    import sib_pkg::*;
    import sib_tb_pkg::*;

    localparam int HOLD_LEN = 600;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       max_entries_we = 1'b0;
    logic [4:0] max_entries_wd = '0;

    sib_if #(.PAYLOAD_T(req_t)) req_ch ();
    sib_if #(.PAYLOAD_T(res_t)) res_ch ();

    snapshot_interpolation_buffer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch.sink),
        .res            (res_ch.source),
        .max_entries_we (max_entries_we),
        .max_entries_wd (max_entries_wd)
    );

    req_t        pending_reqs [$];
    res_t        expected_poses [$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off = 1'b0;
    int          hold_cycles = 0;
    int          errors = 0;
    int          beats_in = 0;
    int          popped = 0;
    int          beats_out = 0;
    int          blends_seen = 0;
    longint      cycle = 0;
    logic [63:0] base_stamp;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        res_ch.ready = 1'b0;
    end

    // driver: advance on accepted beat, change inputs at the falling edge
    always @(negedge clk)
    begin
        bit taken;
        taken = (beats_in != popped);
        if (rst_n)
        begin
            if (taken)
            begin
                pending_reqs.delete(0);
                popped++;
            end
            if (req_ch.valid && !taken)
                req_ch.valid <= 1'b1;
            else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req_ch.valid <= 1'b1;
                req_ch.data  <= pending_reqs[0];
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // receiver: hold off for one long stretch, otherwise stall at random
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off && hold_cycles < HOLD_LEN)
                hold_cycles++;
            res_ch.ready <= !(hold_off && hold_cycles < HOLD_LEN) &&
                            $urandom_range(99) >= recv_stall_pct;
        end
    end

    // predict at acceptance, check results
    always @(posedge clk)
    begin
        cycle++;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            beats_in++;
            if (req_ch.data.req_type == REQ_INSERT)
                pose_insert(req_ch.data);
            else
                expected_poses.push_back(pose_sample(req_ch.data.stamp));
        end
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            beats_out++;
            if (expected_poses.size() == 0)
            begin
                $error("unexpected result beat");
                errors++;
            end
            else
            begin
                res_t e, a;
                e = expected_poses[0];
                expected_poses.delete(0);
                a = res_ch.data;
                if (e.blended) blends_seen++;
                if (a.found !== e.found) begin $error("found exp %0h got %0h", e.found, a.found); errors++; end
                if (a.out_stamp !== e.out_stamp) begin $error("out_stamp exp %0h got %0h", e.out_stamp, a.out_stamp); errors++; end
                if (a.out_x !== e.out_x) begin $error("out_x exp %0h got %0h", e.out_x, a.out_x); errors++; end
                if (a.out_y !== e.out_y) begin $error("out_y exp %0h got %0h", e.out_y, a.out_y); errors++; end
                if (a.out_z !== e.out_z) begin $error("out_z exp %0h got %0h", e.out_z, a.out_z); errors++; end
                if (a.out_pitch !== e.out_pitch) begin $error("out_pitch exp %0h got %0h", e.out_pitch, a.out_pitch); errors++; end
                if (a.out_yaw !== e.out_yaw) begin $error("out_yaw exp %0h got %0h", e.out_yaw, a.out_yaw); errors++; end
                if (a.out_roll !== e.out_roll) begin $error("out_roll exp %0h got %0h", e.out_roll, a.out_roll); errors++; end
                if (a.blend !== e.blend) begin $error("blend exp %0h got %0h", e.blend, a.blend); errors++; end
                if (a.blended !== e.blended) begin $error("blended exp %0h got %0h", e.blended, a.blended); errors++; end
            end
        end
        if (cycle > 3000000)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic req_t rand_req(logic kind, logic [63:0] st);
        req_t r;
        r.req_type  = kind;
        r.stamp     = st;
        r.pos_x     = $urandom;
        r.pos_y     = $urandom;
        r.pos_z     = $urandom;
        r.ang_pitch = 16'($urandom);
        r.ang_yaw   = 16'($urandom);
        r.ang_roll  = 16'($urandom);
        return r;
    endfunction

    function automatic logic [63:0] rand_stamp();
        return {$urandom, $urandom};
    endfunction

    task automatic drain();
        wait (pending_reqs.size() == 0 && !(req_ch.valid));
        wait (expected_poses.size() == 0);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_limit(logic [4:0] v);
        @(negedge clk);
        max_entries_we <= 1'b1;
        max_entries_wd <= v;
        @(negedge clk);
        max_entries_we <= 1'b0;
        pose_set_limit(v);
    endtask

    // a stream of inserts near a moving base, with samples in between
    task automatic queue_stream(int count, int ins_pct);
        logic [63:0] st;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(9))
                0: st = rand_stamp();
                1: st = base_stamp + 64'($urandom_range(40)) - 64'd20;
                default: st = base_stamp + 64'($urandom_range(3000)) - 64'd1000;
            endcase
            if ($urandom_range(99) < ins_pct)
            begin
                pending_reqs.push_back(rand_req(REQ_INSERT, st));
                base_stamp += 64'($urandom_range(200));
            end
            else
                pending_reqs.push_back(rand_req(REQ_SAMPLE, st));
        end
    endtask

    initial
    begin
        req_t r;
        pose_reset();
        base_stamp = 64'd1000;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty, single, extremes, wrap, equal stamps, limits
        pending_reqs.push_back(rand_req(REQ_SAMPLE, 64'd5));
        r = rand_req(REQ_INSERT, 64'd100);
        r.pos_x = 32'h8000_0000; r.ang_pitch = 16'h8000; r.ang_yaw = 16'h7FFF;
        pending_reqs.push_back(r);
        pending_reqs.push_back(rand_req(REQ_SAMPLE, 64'd150));
        r = rand_req(REQ_INSERT, 64'd200);
        r.pos_x = 32'h7FFF_FFFF; r.ang_pitch = 16'h0000; r.ang_yaw = 16'h8000;
        pending_reqs.push_back(r);
        pending_reqs.push_back(rand_req(REQ_SAMPLE, 64'd0));
        pending_reqs.push_back(rand_req(REQ_SAMPLE, 64'd100));
        pending_reqs.push_back(rand_req(REQ_SAMPLE, 64'd101));
        pending_reqs.push_back(rand_req(REQ_SAMPLE, 64'd199));
        pending_reqs.push_back(rand_req(REQ_SAMPLE, 64'd200));
        pending_reqs.push_back(rand_req(REQ_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF));
        pending_reqs.push_back(rand_req(REQ_INSERT, 64'd200));
        pending_reqs.push_back(rand_req(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF));
        pending_reqs.push_back(rand_req(REQ_INSERT, 64'd0));
        pending_reqs.push_back(rand_req(REQ_SAMPLE, 64'h8000_0000_0000_0000));
        pending_reqs.push_back(rand_req(REQ_SAMPLE, 64'd150));
        for (int i = 0; i < 18; i++)
            pending_reqs.push_back(rand_req(REQ_INSERT, 64'd300 + 64'(i * 7)));
        pending_reqs.push_back(rand_req(REQ_INSERT, 64'd1));
        pending_reqs.push_back(rand_req(REQ_SAMPLE, 64'd310));
        drain();

        write_limit(5'd1);
        pending_reqs.push_back(rand_req(REQ_INSERT, 64'd50));
        pending_reqs.push_back(rand_req(REQ_INSERT, 64'd60));
        pending_reqs.push_back(rand_req(REQ_SAMPLE, 64'd55));
        drain();
        write_limit(5'd0);
        pending_reqs.push_back(rand_req(REQ_INSERT, 64'd70));
        pending_reqs.push_back(rand_req(REQ_SAMPLE, 64'd70));
        drain();
        write_limit(5'd31);

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            case (phase)
                1: write_limit(5'd2);
                2: write_limit(5'd16);
                4: write_limit(5'd3);
                5: write_limit(5'd17);
                6: write_limit(5'($urandom_range(1, 15)));
                7: write_limit(5'd0);
                default: ;
            endcase
            if (phase == 0)
            begin
                // long receiver hold-off while samples keep coming
                hold_off = 1'b1;
                for (int i = 0; i < 20; i++)
                    pending_reqs.push_back(rand_req(REQ_SAMPLE, base_stamp));
            end
            queue_stream(phase == 7 ? 60 : 200, phase == 7 ? 70 : 55);
            if (phase == 7)
            begin
                drain();
                write_limit(5'd16);
                queue_stream(180, 55);
            end
            drain();
        end

        $display("covered %0d request beats and %0d pose results, %0d interpolated",
                 beats_in, beats_out, blends_seen);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
